// ===== design/bbged_pkg.sv =====
`timescale 1ns / 1ps

package bbged_pkg;

    localparam int MaxCols = 1024;
    localparam int MaxRows = 1024;
    localparam int MaxBlur = 31;
    localparam int PosW    = 21;
    localparam int AddrW   = 20;
    localparam int DivBits = 13;
    localparam int Recip3  = 683;
    localparam int Recip3Sh = 11;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_BLUR   = 2'd2,
        REG_THRESH = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        SUM_HORZ = 1'b0,
        SUM_VERT = 1'b1
    } sum_sel_t;

    typedef struct packed {
        logic     take;
        logic     m_first;
        logic     m_init;
        logic     v_init;
        logic     h_init;
        logic     h_acc;
        logic     div_start;
        sum_sel_t div_sel;
        logic     h_done;
        logic     v_done;
        logic     v_next;
        logic     m_done;
        logic     emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic border;
        logic v_skip;
        logic j_last;
        logic i_last;
        logic vi_last;
        logic mi_last;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/bbged_ifs.sv =====
`timescale 1ns / 1ps

interface bbged_pix_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, func, red, green, blue, input ready);
    modport sink (input valid, func, red, green, blue, output ready);
endinterface

interface bbged_res_if;
    logic       valid;
    logic       ready;
    logic       edge_res;
    logic [7:0] strength;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       end_of_frame;
    modport source (output valid, edge_res, strength, out_row, out_col, end_of_frame,
                    input ready);
    modport sink (input valid, edge_res, strength, out_row, out_col, end_of_frame,
                  output ready);
endinterface

interface bbged_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== design/box_blur_gradient_edge_detect.sv =====
// an item that releases no result goes back to idle from the check state; a border result goes
// on to the finish state; an interior result runs the window loops, whose length grows with R and C,
// the clipped blur window rows and columns, through the single gray frame memory read port and the 13-step divider
// items are handled one at a time; the next item is taken while a result waits in the output register
// reset: registers return to 640 x 480, blur 5, threshold 45, frame positions cleared
`timescale 1ns / 1ps

module box_blur_gradient_edge_detect (
    input  logic        clk,
    input  logic        rst_n,
    bbged_pix_if.sink   pixel,
    bbged_res_if.source result,
    bbged_cfg_if.sink   cfg
);
    import bbged_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bbged_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .cmd      (cmd),
        .status   (status)
    );

    bbged_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_func  (pixel.func),
        .pix_red   (pixel.red),
        .pix_green (pixel.green),
        .pix_blue  (pixel.blue),
        .cmd       (cmd),
        .status    (status),
        .result    (result),
        .cfg       (cfg)
    );

endmodule

// ===== design/bbged_div.sv =====
`timescale 1ns / 1ps

module bbged_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [12:0] dividend,
    input  logic [4:0] divisor,
    output logic       done,
    output logic [7:0] quotient
);
    import bbged_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [4:0]  rem_reg;
    logic [4:0]  dvs_reg;
    logic [DivBits-1:0] quo_reg;
    logic [5:0]  trial;
    logic [5:0]  diff;
    logic        fits;

    assign trial = {rem_reg, quo_reg[DivBits-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(DivBits - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[4:0] : trial[4:0];
            quo_reg <= {quo_reg[DivBits-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[7:0];

endmodule

// ===== design/bbged_dp.sv =====
`timescale 1ns / 1ps

module bbged_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_func,
    input  logic [7:0]             pix_red,
    input  logic [7:0]             pix_green,
    input  logic [7:0]             pix_blue,
    input  bbged_pkg::ctrl_cmd_t   cmd,
    output bbged_pkg::dp_status_t  status,
    bbged_res_if.source            result,
    bbged_cfg_if.sink              cfg
);
    import bbged_pkg::*;

    typedef enum logic [2:0] {
        NB_CENTER = 3'd0,
        NB_UP     = 3'd1,
        NB_DOWN   = 3'd2,
        NB_LEFT   = 3'd3,
        NB_RIGHT  = 3'd4
    } nb_t;

    function automatic logic signed [12:0] off_y(input nb_t n);
        case (n)
            NB_UP:   off_y = -13'sd1;
            NB_DOWN: off_y = 13'sd1;
            default: off_y = 13'sd0;
        endcase
    endfunction

    function automatic logic signed [12:0] off_x(input nb_t n);
        case (n)
            NB_LEFT:  off_x = -13'sd1;
            NB_RIGHT: off_x = 13'sd1;
            default:  off_x = 13'sd0;
        endcase
    endfunction

    // configuration and positions
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [4:0]  blur_reg;
    logic [7:0]  thresh_reg;
    logic [PosW-1:0] inpos_reg;
    logic [PosW-1:0] outpos_reg;
    logic [10:0] in_row_reg;
    logic [9:0]  in_col_reg;
    logic [9:0]  orow_reg;
    logic [9:0]  ocol_reg;
    logic        out_valid_reg;

    // window loop state
    nb_t         mi_reg;
    nb_t         vi_reg;
    logic [9:0]  i_reg;
    logic [9:0]  j_reg;
    logic [12:0] hsum_reg;
    logic [12:0] vsum_reg;
    logic [7:0]  vc_reg;
    logic [9:0]  msum_reg;
    logic [7:0]  mag_reg [5];
    logic [7:0]  rdata_reg;
    logic [7:0]  gray_mem [0:MaxCols*MaxRows-1];

    logic        edge_q_reg;
    logic [7:0]  strength_q_reg;
    logic [9:0]  row_q_reg;
    logic [9:0]  col_q_reg;
    logic        eof_q_reg;

    logic [10:0] w_eff;
    logic [10:0] h_eff;
    logic [4:0]  k_eff;
    logic [3:0]  half;
    logic [4:0]  ahead;
    logic [21:0] total_full;
    logic [PosW-1:0] total;
    logic [15:0] lag;
    logic [21:0] need_pos;
    logic        emit_ok;
    logic        take_ok;
    logic        in_col_last;
    logic        out_col_last;
    logic        out_last;
    logic        border;
    logic [9:0]  sum3;
    logic [19:0] gray_prod;
    logic [7:0]  gray;

    logic signed [12:0] my_s, mx_s, vy_s, vx_s;
    logic signed [12:0] rlo_s, rhi_s, clo_s, chi_s;
    logic signed [12:0] h_s, w_s, half_s, k_s;
    logic [10:0] rlo, rhi, clo, chi;
    logic [10:0] rdiff, cdiff;
    logic        v_skip;

    logic        div_done;
    logic [7:0]  quot;
    logic [12:0] div_num;
    logic [4:0]  div_den;
    logic [7:0]  adiff;
    logic [11:0] m3;
    logic [7:0]  m_sat;
    logic        ymax, xmax;
    logic [7:0]  s_val;

    // effective register values
    always_comb
    begin
        if (width_reg == 11'd0)
            w_eff = 11'd1;
        else if (width_reg > 11'(MaxCols))
            w_eff = 11'(MaxCols);
        else
            w_eff = width_reg;
        if (height_reg == 11'd0)
            h_eff = 11'd1;
        else if (height_reg > 11'(MaxRows))
            h_eff = 11'(MaxRows);
        else
            h_eff = height_reg;
        if (blur_reg == 5'd0)
            k_eff = 5'd1;
        else if (blur_reg > 5'(MaxBlur))
            k_eff = 5'(MaxBlur);
        else
            k_eff = blur_reg;
    end

    assign half       = k_eff[4:1];
    assign ahead      = k_eff - 5'd1 - {1'b0, half};
    assign total_full = {11'd0, w_eff} * {11'd0, h_eff};
    assign total      = total_full[PosW-1:0];
    assign lag        = {11'd0, ahead + 5'd3} * {5'd0, w_eff};
    assign need_pos   = {1'b0, outpos_reg} + {6'd0, lag};
    assign emit_ok    = (outpos_reg < total) &&
                        ((inpos_reg >= total) || (need_pos <= {1'b0, inpos_reg}));
    assign take_ok    = cmd.take && !pix_func && (inpos_reg < total);
    assign in_col_last  = ({1'b0, in_col_reg} + 11'd1) == w_eff;
    assign out_col_last = ({1'b0, ocol_reg} + 11'd1) == w_eff;
    assign out_last     = (outpos_reg + 21'd1) == total;
    assign border = !((orow_reg != 10'd0) && (ocol_reg != 10'd0) &&
                      (({1'b0, orow_reg} + 11'd1) < h_eff) &&
                      (({1'b0, ocol_reg} + 11'd1) < w_eff));

    // gray as floor(sum / 3) by reciprocal
    assign sum3      = {2'b0, pix_red} + {2'b0, pix_green} + {2'b0, pix_blue};
    assign gray_prod = {10'd0, sum3} * 20'(Recip3);
    assign gray      = gray_prod[Recip3Sh+7:Recip3Sh];

    // window geometry
    assign h_s    = $signed({2'b0, h_eff});
    assign w_s    = $signed({2'b0, w_eff});
    assign half_s = $signed({9'b0, half});
    assign k_s    = $signed({8'b0, k_eff});
    assign my_s   = $signed({3'b0, orow_reg}) + off_y(mi_reg);
    assign mx_s   = $signed({3'b0, ocol_reg}) + off_x(mi_reg);
    assign vy_s   = my_s + off_y(vi_reg);
    assign vx_s   = mx_s + off_x(vi_reg);
    assign rlo_s  = vy_s - half_s;
    assign rhi_s  = rlo_s + k_s;
    assign clo_s  = vx_s - half_s;
    assign chi_s  = clo_s + k_s;
    assign rlo    = (rlo_s < 13'sd0) ? 11'd0 : rlo_s[10:0];
    assign rhi    = (rhi_s > h_s) ? h_eff : rhi_s[10:0];
    assign clo    = (clo_s < 13'sd0) ? 11'd0 : clo_s[10:0];
    assign chi    = (chi_s > w_s) ? w_eff : chi_s[10:0];
    assign rdiff  = rhi - rlo;
    assign cdiff  = chi - clo;

    always_comb
    begin
        case (vi_reg)
            NB_UP:    v_skip = (my_s == 13'sd0);
            NB_DOWN:  v_skip = ((my_s + 13'sd1) >= h_s);
            NB_LEFT:  v_skip = (mx_s == 13'sd0);
            NB_RIGHT: v_skip = ((mx_s + 13'sd1) >= w_s);
            default:  v_skip = 1'b0;
        endcase
    end

    assign div_num = (cmd.div_sel == SUM_VERT) ? vsum_reg : hsum_reg;
    assign div_den = (cmd.div_sel == SUM_VERT) ? rdiff[4:0] : cdiff[4:0];

    bbged_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (quot)
    );

    assign adiff = (quot > vc_reg) ? (quot - vc_reg) : (vc_reg - quot);
    assign m3    = {1'b0, msum_reg, 1'b0} + {2'b0, msum_reg};
    assign m_sat = (m3 > 12'd255) ? 8'd255 : m3[7:0];

    assign ymax  = (mag_reg[0] > mag_reg[1]) && (mag_reg[0] >= mag_reg[2]);
    assign xmax  = (mag_reg[0] > mag_reg[3]) && (mag_reg[0] >= mag_reg[4]);
    assign s_val = (!border && (ymax || xmax)) ? mag_reg[0] : 8'd0;

    always_comb
    begin
        status.emit_ok  = emit_ok;
        status.border   = border;
        status.v_skip   = v_skip;
        status.j_last   = ({1'b0, j_reg} + 11'd1) == chi;
        status.i_last   = ({1'b0, i_reg} + 11'd1) == rhi;
        status.vi_last  = (vi_reg == NB_RIGHT);
        status.mi_last  = (mi_reg == NB_RIGHT);
        status.div_done = div_done;
        status.out_free = !out_valid_reg || result.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'd640;
            height_reg    <= 11'd480;
            blur_reg      <= 5'd5;
            thresh_reg    <= 8'd45;
            inpos_reg     <= '0;
            outpos_reg    <= '0;
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            orow_reg      <= '0;
            ocol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid || (cmd.emit && out_last))
            begin
                if (cfg.valid)
                begin
                    case (cfg_reg_t'(cfg.index))
                        REG_WIDTH:  width_reg  <= cfg.data;
                        REG_HEIGHT: height_reg <= cfg.data;
                        REG_BLUR:   blur_reg   <= cfg.data[4:0];
                        REG_THRESH: thresh_reg <= cfg.data[7:0];
                        default:    ;
                    endcase
                end
                inpos_reg  <= '0;
                outpos_reg <= '0;
                in_row_reg <= '0;
                in_col_reg <= '0;
                orow_reg   <= '0;
                ocol_reg   <= '0;
            end
            else
            begin
                if (take_ok)
                begin
                    inpos_reg <= inpos_reg + 21'd1;
                    if (in_col_last)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + 11'd1;
                    end
                    else
                        in_col_reg <= in_col_reg + 10'd1;
                end
                if (cmd.emit)
                begin
                    outpos_reg <= outpos_reg + 21'd1;
                    if (out_col_last)
                    begin
                        ocol_reg <= '0;
                        orow_reg <= orow_reg + 10'd1;
                    end
                    else
                        ocol_reg <= ocol_reg + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_ok)
            gray_mem[{in_row_reg[9:0], in_col_reg}] <= gray;
        rdata_reg <= gray_mem[{i_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.m_first)
            mi_reg <= NB_CENTER;
        if (cmd.m_init)
        begin
            vi_reg   <= NB_CENTER;
            msum_reg <= '0;
        end
        if (cmd.v_init)
        begin
            i_reg    <= rlo[9:0];
            vsum_reg <= '0;
        end
        if (cmd.h_init)
        begin
            j_reg    <= clo[9:0];
            hsum_reg <= '0;
        end
        if (cmd.h_acc)
        begin
            hsum_reg <= hsum_reg + {5'd0, rdata_reg};
            if (!status.j_last)
                j_reg <= j_reg + 10'd1;
        end
        if (cmd.h_done)
        begin
            vsum_reg <= vsum_reg + {5'd0, quot};
            if (!status.i_last)
                i_reg <= i_reg + 10'd1;
        end
        if (cmd.v_done)
        begin
            if (vi_reg == NB_CENTER)
                vc_reg <= quot;
            else
                msum_reg <= msum_reg + {2'd0, adiff};
        end
        if (cmd.v_next)
            vi_reg <= nb_t'(vi_reg + 3'd1);
        if (cmd.m_done)
        begin
            mag_reg[mi_reg] <= m_sat;
            if (!status.mi_last)
                mi_reg <= nb_t'(mi_reg + 3'd1);
        end
        if (cmd.emit)
        begin
            edge_q_reg     <= s_val > thresh_reg;
            strength_q_reg <= s_val;
            row_q_reg      <= orow_reg;
            col_q_reg      <= ocol_reg;
            eof_q_reg      <= out_last;
        end
    end

    assign cfg.ready           = 1'b1;
    assign result.valid        = out_valid_reg;
    assign result.edge_res     = edge_q_reg;
    assign result.strength     = strength_q_reg;
    assign result.out_row      = row_q_reg;
    assign result.out_col      = col_q_reg;
    assign result.end_of_frame = eof_q_reg;

    a_out_behind_in: assert property (@(posedge clk) disable iff (!rst_n)
        outpos_reg <= inpos_reg)
        else $error("output position ahead of input position");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, in_col_reg} < w_eff)
        else $error("input column outside the row");

    a_emit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (outpos_reg < total) && status.out_free)
        else $error("transaction emitted past frame end or into a full register");

endmodule

// ===== design/bbged_ctrl.sv =====
`timescale 1ns / 1ps

module bbged_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output bbged_pkg::ctrl_cmd_t  cmd,
    input  bbged_pkg::dp_status_t status
);
    import bbged_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_M_INIT,
        ST_V_INIT,
        ST_H_INIT,
        ST_H_RD,
        ST_H_ACC,
        ST_H_DSTART,
        ST_H_DWAIT,
        ST_V_DSTART,
        ST_V_DWAIT,
        ST_V_NEXT,
        ST_M_DONE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = SUM_HORZ;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.emit_ok)
                    state_next = ST_IDLE;
                else if (status.border)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.m_first = 1'b1;
                    state_next  = ST_M_INIT;
                end
            end
            ST_M_INIT:
            begin
                cmd.m_init = 1'b1;
                state_next = ST_V_INIT;
            end
            ST_V_INIT:
            begin
                if (status.v_skip)
                    state_next = ST_V_NEXT;
                else
                begin
                    cmd.v_init = 1'b1;
                    state_next = ST_H_INIT;
                end
            end
            ST_H_INIT:
            begin
                cmd.h_init = 1'b1;
                state_next = ST_H_RD;
            end
            ST_H_RD:
                state_next = ST_H_ACC;
            ST_H_ACC:
            begin
                cmd.h_acc  = 1'b1;
                state_next = status.j_last ? ST_H_DSTART : ST_H_RD;
            end
            ST_H_DSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SUM_HORZ;
                state_next    = ST_H_DWAIT;
            end
            ST_H_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.h_done = 1'b1;
                    state_next = status.i_last ? ST_V_DSTART : ST_H_INIT;
                end
            end
            ST_V_DSTART:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SUM_VERT;
                state_next    = ST_V_DWAIT;
            end
            ST_V_DWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.v_done = 1'b1;
                    state_next = ST_V_NEXT;
                end
            end
            ST_V_NEXT:
            begin
                if (status.vi_last)
                    state_next = ST_M_DONE;
                else
                begin
                    cmd.v_next = 1'b1;
                    state_next = ST_V_INIT;
                end
            end
            ST_M_DONE:
            begin
                cmd.m_done = 1'b1;
                state_next = status.mi_last ? ST_FINISH : ST_M_INIT;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule
